// ----- rtl/pcc_pkg.sv -----
// ----------------------------------------------------------------------------
// pcc_pkg
// Shared constants and register map of the cooling-fan PID controller.
// ----------------------------------------------------------------------------
`default_nettype none

package pcc_pkg;

    // Default datapath width and fraction bits (signed fixed point)
    localparam int DATA_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF  = 16;

    // Width of every field on the ports
    localparam int FIELD_W   = 32;
    localparam int NUM_REGS  = 8;
    localparam int REG_IDX_W = 3;

    // Configuration register map
    typedef enum logic [REG_IDX_W-1:0] {
        REG_PROP_GAIN     = 3'd0,
        REG_INT_STEP_GAIN = 3'd1,
        REG_DERIV_GAIN    = 3'd2,
        REG_DERIV_POLE    = 3'd3,
        REG_OUT_MIN       = 3'd4,
        REG_OUT_MAX       = 3'd5,
        REG_INTEG_MIN     = 3'd6,
        REG_INTEG_MAX     = 3'd7
    } cfg_reg_t;

    // Reset values of the upper clamps: 100.0 in Q16.16
    localparam logic [FIELD_W-1:0] OUT_MAX_RST   = 32'h0064_0000;
    localparam logic [FIELD_W-1:0] INTEG_MAX_RST = 32'h0064_0000;

endpackage

`default_nettype wire

// ----- rtl/pcc_mul.sv -----
// ----------------------------------------------------------------------------
// pcc_mul
// Fixed-point multiply: full product, floor shift by the fraction bits,
// saturate to the datapath width.
// ----------------------------------------------------------------------------
`default_nettype none

module pcc_mul #(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  wire logic signed [DATA_WIDTH-1:0] a,
    input  wire logic signed [DATA_WIDTH-1:0] b,
    output logic signed [DATA_WIDTH-1:0]      p
);
    localparam int PW = 2 * DATA_WIDTH;
    localparam logic signed [DATA_WIDTH-1:0] DMAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
    localparam logic signed [DATA_WIDTH-1:0] DMIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

    logic signed [PW-1:0] prod;
    logic signed [PW-1:0] shifted;
    logic                 fits;

    always_comb begin
        prod    = PW'(a) * PW'(b);
        // arithmetic shift gives rounding toward minus infinity
        shifted = prod >>> FRAC_BITS;
        fits    = (&shifted[PW-1:DATA_WIDTH-1]) | ~(|shifted[PW-1:DATA_WIDTH-1]);
        if (fits) begin
            p = shifted[DATA_WIDTH-1:0];
        end else if (shifted[PW-1]) begin
            p = DMIN;
        end else begin
            p = DMAX;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/pcc_front.sv -----
// ----------------------------------------------------------------------------
// pcc_front
// Input register and error stage: forms the error, the idle flag, the
// trapezoid error sum and the measurement step; owns last_error and
// last_sensed.
// ----------------------------------------------------------------------------
`default_nettype none

module pcc_front #(
    parameter int DATA_WIDTH = pcc_pkg::DATA_WIDTH_DEF
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic [pcc_pkg::FIELD_W-1:0]   target_value,
    input  wire logic [pcc_pkg::FIELD_W-1:0]   sensed_value,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic signed [DATA_WIDTH-1:0]       err,
    output logic signed [DATA_WIDTH-1:0]       err_sum,
    output logic signed [DATA_WIDTH-1:0]       sensed_step,
    output logic                               idle
);
    import pcc_pkg::*;

    localparam int XW = (DATA_WIDTH > FIELD_W) ? DATA_WIDTH : FIELD_W;
    localparam logic signed [DATA_WIDTH-1:0] DMAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
    localparam logic signed [DATA_WIDTH-1:0] DMIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

    function automatic logic signed [DATA_WIDTH-1:0] from32(input logic [FIELD_W-1:0] x);
        logic signed [XW-1:0] w;
        w = XW'(signed'(x));
        if (w > XW'(DMAX)) begin
            return DMAX;
        end else if (w < XW'(DMIN)) begin
            return DMIN;
        end
        return DATA_WIDTH'(w);
    endfunction

    function automatic logic signed [DATA_WIDTH-1:0] sat_add(
        input logic signed [DATA_WIDTH-1:0] a,
        input logic signed [DATA_WIDTH-1:0] b
    );
        logic signed [DATA_WIDTH:0] s;
        s = (DATA_WIDTH+1)'(a) + (DATA_WIDTH+1)'(b);
        if (s[DATA_WIDTH] != s[DATA_WIDTH-1]) begin
            return s[DATA_WIDTH] ? DMIN : DMAX;
        end
        return s[DATA_WIDTH-1:0];
    endfunction

    function automatic logic signed [DATA_WIDTH-1:0] sat_sub(
        input logic signed [DATA_WIDTH-1:0] a,
        input logic signed [DATA_WIDTH-1:0] b
    );
        logic signed [DATA_WIDTH:0] s;
        s = (DATA_WIDTH+1)'(a) - (DATA_WIDTH+1)'(b);
        if (s[DATA_WIDTH] != s[DATA_WIDTH-1]) begin
            return s[DATA_WIDTH] ? DMIN : DMAX;
        end
        return s[DATA_WIDTH-1:0];
    endfunction

    // stage 1
    logic                          v1_reg;
    logic signed [DATA_WIDTH-1:0]  err1_reg;
    logic signed [DATA_WIDTH-1:0]  sensed1_reg;
    // stage 2
    logic                          v2_reg;
    logic signed [DATA_WIDTH-1:0]  err2_reg;
    logic signed [DATA_WIDTH-1:0]  esum2_reg;
    logic signed [DATA_WIDTH-1:0]  step2_reg;
    logic                          idle2_reg;
    // history
    logic signed [DATA_WIDTH-1:0]  last_error_reg, last_error_next;
    logic signed [DATA_WIDTH-1:0]  last_sensed_reg, last_sensed_next;

    logic signed [DATA_WIDTH-1:0]  sensed_in;
    logic signed [DATA_WIDTH-1:0]  err_in;
    logic                          rdy2;
    logic                          adv1;
    logic                          idle1;

    assign rdy2     = !v2_reg || out_ready;
    assign in_ready = !v1_reg || rdy2;
    assign adv1     = v1_reg && rdy2;
    assign idle1    = err1_reg[DATA_WIDTH-1];

    always_comb begin
        sensed_in = from32(sensed_value);
        err_in    = sat_sub(sensed_in, from32(target_value));
    end

    // negative error clears the error history; the measurement history holds
    always_comb begin
        last_error_next  = idle1 ? '0 : err1_reg;
        last_sensed_next = idle1 ? last_sensed_reg : sensed1_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg          <= 1'b0;
            v2_reg          <= 1'b0;
            last_error_reg  <= '0;
            last_sensed_reg <= '0;
        end else begin
            if (in_ready) begin
                v1_reg <= in_valid;
            end
            if (rdy2) begin
                v2_reg <= v1_reg;
            end
            if (adv1) begin
                last_error_reg  <= last_error_next;
                last_sensed_reg <= last_sensed_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            err1_reg    <= err_in;
            sensed1_reg <= sensed_in;
        end
        if (adv1) begin
            err2_reg  <= err1_reg;
            esum2_reg <= sat_add(err1_reg, last_error_reg);
            step2_reg <= sat_sub(sensed1_reg, last_sensed_reg);
            idle2_reg <= idle1;
        end
    end

    assign out_valid   = v2_reg;
    assign err         = err2_reg;
    assign err_sum     = esum2_reg;
    assign sensed_step = step2_reg;
    assign idle        = idle2_reg;

endmodule

`default_nettype wire

// ----- rtl/pcc_core.sv -----
// ----------------------------------------------------------------------------
// pcc_core
// Gain products, then the integrator and derivative filter state update.
// ----------------------------------------------------------------------------
`default_nettype none

module pcc_core #(
    parameter int DATA_WIDTH = pcc_pkg::DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = pcc_pkg::FRAC_BITS_DEF
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         in_valid,
    output logic                              in_ready,
    input  wire logic signed [DATA_WIDTH-1:0] err,
    input  wire logic signed [DATA_WIDTH-1:0] err_sum,
    input  wire logic signed [DATA_WIDTH-1:0] sensed_step,
    input  wire logic                         idle,
    input  wire logic signed [DATA_WIDTH-1:0] prop_gain,
    input  wire logic signed [DATA_WIDTH-1:0] integral_step_gain,
    input  wire logic signed [DATA_WIDTH-1:0] deriv_gain,
    input  wire logic signed [DATA_WIDTH-1:0] deriv_pole,
    input  wire logic signed [DATA_WIDTH-1:0] integ_min,
    input  wire logic signed [DATA_WIDTH-1:0] integ_max,
    output logic                              out_valid,
    input  wire logic                         out_ready,
    output logic signed [DATA_WIDTH-1:0]      prop,
    output logic signed [DATA_WIDTH-1:0]      integ,
    output logic signed [DATA_WIDTH-1:0]      slope,
    output logic                              out_idle
);
    localparam logic signed [DATA_WIDTH-1:0] DMAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
    localparam logic signed [DATA_WIDTH-1:0] DMIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

    function automatic logic signed [DATA_WIDTH-1:0] sat_add(
        input logic signed [DATA_WIDTH-1:0] a,
        input logic signed [DATA_WIDTH-1:0] b
    );
        logic signed [DATA_WIDTH:0] s;
        s = (DATA_WIDTH+1)'(a) + (DATA_WIDTH+1)'(b);
        if (s[DATA_WIDTH] != s[DATA_WIDTH-1]) begin
            return s[DATA_WIDTH] ? DMIN : DMAX;
        end
        return s[DATA_WIDTH-1:0];
    endfunction

    // stage 3: products
    logic                         v3_reg;
    logic signed [DATA_WIDTH-1:0] prop3_reg;
    logic signed [DATA_WIDTH-1:0] pint3_reg;
    logic signed [DATA_WIDTH-1:0] pder3_reg;
    logic                         idle3_reg;
    // stage 4: controller state
    logic                         v4_reg;
    logic signed [DATA_WIDTH-1:0] prop4_reg;
    logic                         idle4_reg;
    logic signed [DATA_WIDTH-1:0] integral_acc_reg, integral_acc_next;
    logic signed [DATA_WIDTH-1:0] filtered_slope_reg, filtered_slope_next;

    logic signed [DATA_WIDTH-1:0] prop_p, pint_p, pder_p, pole_p;
    logic signed [DATA_WIDTH-1:0] acc_sum;
    logic                         rdy4;
    logic                         adv2;
    logic                         adv3;

    assign rdy4     = !v4_reg || out_ready;
    assign in_ready = !v3_reg || rdy4;
    assign adv2     = in_valid && in_ready;
    assign adv3     = v3_reg && rdy4;

    pcc_mul #(.DATA_WIDTH(DATA_WIDTH), .FRAC_BITS(FRAC_BITS)) u_mul_prop (
        .a(prop_gain), .b(err), .p(prop_p)
    );
    pcc_mul #(.DATA_WIDTH(DATA_WIDTH), .FRAC_BITS(FRAC_BITS)) u_mul_int (
        .a(integral_step_gain), .b(err_sum), .p(pint_p)
    );
    pcc_mul #(.DATA_WIDTH(DATA_WIDTH), .FRAC_BITS(FRAC_BITS)) u_mul_der (
        .a(deriv_gain), .b(sensed_step), .p(pder_p)
    );
    // filter feedback: one multiply and one add in the loop
    pcc_mul #(.DATA_WIDTH(DATA_WIDTH), .FRAC_BITS(FRAC_BITS)) u_mul_pole (
        .a(deriv_pole), .b(filtered_slope_reg), .p(pole_p)
    );

    always_comb begin
        acc_sum = sat_add(integral_acc_reg, pint3_reg);
        // upper limit tested first
        if (acc_sum > integ_max) begin
            integral_acc_next = integ_max;
        end else if (acc_sum < integ_min) begin
            integral_acc_next = integ_min;
        end else begin
            integral_acc_next = acc_sum;
        end
        filtered_slope_next = sat_add(pder3_reg, pole_p);
        if (idle3_reg) begin
            integral_acc_next   = '0;
            filtered_slope_next = filtered_slope_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v3_reg             <= 1'b0;
            v4_reg             <= 1'b0;
            integral_acc_reg   <= '0;
            filtered_slope_reg <= '0;
        end else begin
            if (in_ready) begin
                v3_reg <= in_valid;
            end
            if (rdy4) begin
                v4_reg <= v3_reg;
            end
            if (adv3) begin
                integral_acc_reg   <= integral_acc_next;
                filtered_slope_reg <= filtered_slope_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv2) begin
            prop3_reg <= prop_p;
            pint3_reg <= pint_p;
            pder3_reg <= pder_p;
            idle3_reg <= idle;
        end
        if (adv3) begin
            prop4_reg <= prop3_reg;
            idle4_reg <= idle3_reg;
        end
    end

    assign out_valid = v4_reg;
    assign prop      = prop4_reg;
    assign integ     = integral_acc_reg;
    assign slope     = filtered_slope_reg;
    assign out_idle  = idle4_reg;

endmodule

`default_nettype wire

// ----- rtl/pid_cooling_controller.sv -----
// ----------------------------------------------------------------------------
// pid_cooling_controller
// PID controller for a cooling fan in signed fixed point: proportional term,
// clamped trapezoidal integral and filtered derivative on the measurement.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Beat contents
//  s_       in         tdata: target_value [31:0], sensed_value [63:32]
//  m_       out        tdata: drive [31:0]; tuser: idle
//  cfg_     in         one register write per cycle with cfg_we high
//
//  Five register stages: input/error, error sum and step, gain products,
//  controller state, output. A result beat is registered in each in turn;
//  one beat per cycle is sustained while m_tready is high, set by the
//  derivative filter loop (one multiply and one saturating add) in the
//  state stage. Each stage moves when the next is empty or moving, so bubbles
//  close up and input is taken while a result waits, until all stages fill.
//  aresetn (synchronous) clears all stage valids and the controller state;
//  the clamp registers return to 0 and 100.0.
//  Error = measurement - setpoint; a negative error clears the integrator and
//  the error history, and gives drive 0 with idle set.
//
// ----------------------------------------------------------------------------
`default_nettype none

module pid_cooling_controller #(
    parameter int DATA_WIDTH = pcc_pkg::DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = pcc_pkg::FRAC_BITS_DEF
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    // input stream
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    input  wire logic [2*pcc_pkg::FIELD_W-1:0]   s_tdata,   // target_value, sensed_value
    // result stream
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic [pcc_pkg::FIELD_W-1:0]          m_tdata,   // drive
    output logic                                 m_tuser,   // idle
    // register writes
    input  wire logic                            cfg_we,
    input  wire logic [pcc_pkg::REG_IDX_W-1:0]   cfg_index,
    input  wire logic [pcc_pkg::FIELD_W-1:0]     cfg_wdata
);
    import pcc_pkg::*;

    localparam int XW = (DATA_WIDTH > FIELD_W) ? DATA_WIDTH : FIELD_W;
    localparam logic signed [DATA_WIDTH-1:0] DMAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
    localparam logic signed [DATA_WIDTH-1:0] DMIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

    // 32-bit register value, saturated into the datapath width
    function automatic logic signed [DATA_WIDTH-1:0] from32(input logic [FIELD_W-1:0] x);
        logic signed [XW-1:0] w;
        w = XW'(signed'(x));
        if (w > XW'(DMAX)) begin
            return DMAX;
        end else if (w < XW'(DMIN)) begin
            return DMIN;
        end
        return DATA_WIDTH'(w);
    endfunction

    function automatic logic signed [DATA_WIDTH-1:0] sat_add(
        input logic signed [DATA_WIDTH-1:0] a,
        input logic signed [DATA_WIDTH-1:0] b
    );
        logic signed [DATA_WIDTH:0] s;
        s = (DATA_WIDTH+1)'(a) + (DATA_WIDTH+1)'(b);
        if (s[DATA_WIDTH] != s[DATA_WIDTH-1]) begin
            return s[DATA_WIDTH] ? DMIN : DMAX;
        end
        return s[DATA_WIDTH-1:0];
    endfunction

    // configuration registers
    logic signed [DATA_WIDTH-1:0] prop_gain_reg;
    logic signed [DATA_WIDTH-1:0] int_step_gain_reg;
    logic signed [DATA_WIDTH-1:0] deriv_gain_reg;
    logic signed [DATA_WIDTH-1:0] deriv_pole_reg;
    logic signed [DATA_WIDTH-1:0] out_min_reg;
    logic signed [DATA_WIDTH-1:0] out_max_reg;
    logic signed [DATA_WIDTH-1:0] integ_min_reg;
    logic signed [DATA_WIDTH-1:0] integ_max_reg;
    logic signed [DATA_WIDTH-1:0] cfg_value;

    assign cfg_value = from32(cfg_wdata);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prop_gain_reg     <= '0;
            int_step_gain_reg <= '0;
            deriv_gain_reg    <= '0;
            deriv_pole_reg    <= '0;
            out_min_reg       <= '0;
            out_max_reg       <= from32(OUT_MAX_RST);
            integ_min_reg     <= '0;
            integ_max_reg     <= from32(INTEG_MAX_RST);
        end else if (cfg_we) begin
            unique case (cfg_reg_t'(cfg_index))
                REG_PROP_GAIN:     prop_gain_reg     <= cfg_value;
                REG_INT_STEP_GAIN: int_step_gain_reg <= cfg_value;
                REG_DERIV_GAIN:    deriv_gain_reg    <= cfg_value;
                REG_DERIV_POLE:    deriv_pole_reg    <= cfg_value;
                REG_OUT_MIN:       out_min_reg       <= cfg_value;
                REG_OUT_MAX:       out_max_reg       <= cfg_value;
                REG_INTEG_MIN:     integ_min_reg     <= cfg_value;
                REG_INTEG_MAX:     integ_max_reg     <= cfg_value;
            endcase
        end
    end

    // front end: error, idle, error sum, measurement step
    logic                         fr_valid, fr_ready;
    logic signed [DATA_WIDTH-1:0] fr_err, fr_err_sum, fr_step;
    logic                         fr_idle;

    pcc_front #(.DATA_WIDTH(DATA_WIDTH)) u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_valid     (s_tvalid),
        .in_ready     (s_tready),
        .target_value (s_tdata[FIELD_W-1:0]),
        .sensed_value (s_tdata[2*FIELD_W-1:FIELD_W]),
        .out_valid    (fr_valid),
        .out_ready    (fr_ready),
        .err          (fr_err),
        .err_sum      (fr_err_sum),
        .sensed_step  (fr_step),
        .idle         (fr_idle)
    );

    // products and controller state
    logic                         co_valid, co_ready;
    logic signed [DATA_WIDTH-1:0] co_prop, co_integ, co_slope;
    logic                         co_idle;

    pcc_core #(.DATA_WIDTH(DATA_WIDTH), .FRAC_BITS(FRAC_BITS)) u_core (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .in_valid           (fr_valid),
        .in_ready           (fr_ready),
        .err                (fr_err),
        .err_sum            (fr_err_sum),
        .sensed_step        (fr_step),
        .idle               (fr_idle),
        .prop_gain          (prop_gain_reg),
        .integral_step_gain (int_step_gain_reg),
        .deriv_gain         (deriv_gain_reg),
        .deriv_pole         (deriv_pole_reg),
        .integ_min          (integ_min_reg),
        .integ_max          (integ_max_reg),
        .out_valid          (co_valid),
        .out_ready          (co_ready),
        .prop               (co_prop),
        .integ              (co_integ),
        .slope              (co_slope),
        .out_idle           (co_idle)
    );

    // output stage: sum of terms, output clamp (upper limit first)
    logic                         out_valid_reg;
    logic signed [DATA_WIDTH-1:0] drive_reg, drive_next;
    logic                         idle_reg;
    logic signed [DATA_WIDTH-1:0] sum_pi, sum_all;

    assign co_ready = !out_valid_reg || m_tready;

    always_comb begin
        sum_pi  = sat_add(co_prop, co_integ);
        sum_all = sat_add(sum_pi, co_slope);
        if (sum_all > out_max_reg) begin
            drive_next = out_max_reg;
        end else if (sum_all < out_min_reg) begin
            drive_next = out_min_reg;
        end else begin
            drive_next = sum_all;
        end
        if (co_idle) begin
            drive_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (co_ready) begin
            out_valid_reg <= co_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (co_ready && co_valid) begin
            drive_reg <= drive_next;
            idle_reg  <= co_idle;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = FIELD_W'(drive_reg);
    assign m_tuser  = idle_reg;

endmodule

`default_nettype wire
